// ===== src/wfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfq_pkg;

    // queue geometry
    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 16;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int REG_W   = 7;
    localparam int CMP_W   = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam int HANDLE_W = 16;
    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int MASK_W  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_MASK  = 8'd3;

    localparam logic [REG_W-1:0]  CAPACITY_RST = 7'd64;
    localparam logic [REG_W-1:0]  HIGH_THR_RST = 7'd48;
    localparam logic [REG_W-1:0]  LOW_THR_RST  = 7'd16;
    localparam logic [MASK_W-1:0] EV_MASK_RST  = 4'd0;

    // event enable mask bits
    localparam int MASK_HIGH  = 0;
    localparam int MASK_FULL  = 1;
    localparam int MASK_EMPTY = 2;
    localparam int MASK_LOW   = 3;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_HIGH  = 3'd3,
        ST_LOW   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_HIGH  = 3'd1,
        EV_FULL  = 3'd2,
        EV_EMPTY = 3'd3,
        EV_LOW   = 3'd4
    } t_event;

    typedef struct packed {
        logic [REG_W-1:0]  capacity;
        logic [REG_W-1:0]  high_thr;
        logic [REG_W-1:0]  low_thr;
        logic [MASK_W-1:0] ev_mask;
    } t_cfg;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [STORE_W-1:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
    } t_ring_ctl;

    typedef struct packed {
        t_status          status;
        logic             handle_valid;
        t_event           event_res;
        logic [REG_W-1:0] occupancy;
    } t_result;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        next_idx = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== src/watermark_fifo_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   payload
// in        sink       i_in_valid / o_in_ready     i_cmd, i_buf_handle
// out       source     o_out_valid / i_out_ready   o_status, o_handle_out, o_handle_valid,
//                                                  o_event_res, o_occupancy
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one command per cycle while results drain: the decision is made on the accepting
// edge from the count and pointers, and the result beat appears in the next cycle
// the ring read port is registered, so a popped handle lands with its result beat
// reset clears pointers, count and config; the ring contents stay as they are
// a stalled result beat holds, and a new command is taken as soon as it drains
// cfg writes are always taken

module watermark_fifo_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [wfq_pkg::HANDLE_W-1:0]   i_buf_handle,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [wfq_pkg::HANDLE_W-1:0]   o_handle_out,
    output logic                           o_handle_valid,
    output logic [2:0]                     o_event_res,
    output logic [wfq_pkg::REG_W-1:0]      o_occupancy,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wfq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wfq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wfq_pkg::*;

    t_cfg               cfg;
    t_ring_ctl          ring_ctl;
    t_result            result;
    logic [STORE_W-1:0] rd_data;
    logic               accept;

    logic               r_out_valid;
    t_result            r_result;

    // a new beat may enter when the result slot is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    wfq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    wfq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_buf_handle (i_buf_handle),
        .i_cfg        (cfg),
        .o_ring       (ring_ctl),
        .o_result     (result)
    );

    wfq_ring u_ring (
        .i_clk     (i_clk),
        .i_ctl     (ring_ctl),
        .o_rd_data (rd_data)
    );

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_handle_valid = r_result.handle_valid;
    assign o_event_res    = r_result.event_res;
    assign o_occupancy    = r_result.occupancy;
    // handle shows only on a delivering pop
    assign o_handle_out   = r_result.handle_valid ? HANDLE_W'(rd_data) : '0;

endmodule

`default_nettype wire

// ===== src/wfq_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [wfq_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [wfq_pkg::CFG_DATA_W-1:0] i_data,
    output wfq_pkg::t_cfg                  o_cfg
);
    import wfq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= CAPACITY_RST;
            r_cfg.high_thr <= HIGH_THR_RST;
            r_cfg.low_thr  <= LOW_THR_RST;
            r_cfg.ev_mask  <= EV_MASK_RST;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_CAPACITY: r_cfg.capacity <= i_data[REG_W-1:0];
                CFG_HIGH_THR: r_cfg.high_thr <= i_data[REG_W-1:0];
                CFG_LOW_THR:  r_cfg.low_thr  <= i_data[REG_W-1:0];
                CFG_EV_MASK:  r_cfg.ev_mask  <= i_data[MASK_W-1:0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/wfq_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfq_ring (
    input  logic                        i_clk,
    input  wfq_pkg::t_ring_ctl          i_ctl,
    output logic [wfq_pkg::STORE_W-1:0] o_rd_data
);
    import wfq_pkg::*;

    logic [STORE_W-1:0] r_mem [DEPTH];
    logic [STORE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_idx] <= i_ctl.wr_data;
        end
    end

    // read data only moves on a dequeue, so it holds while the result stalls
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/wfq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_cmd,
    input  logic [wfq_pkg::HANDLE_W-1:0] i_buf_handle,
    input  wfq_pkg::t_cfg                i_cfg,
    output wfq_pkg::t_ring_ctl           o_ring,
    output wfq_pkg::t_result             o_result
);
    import wfq_pkg::*;

    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_count,  n_count;

    logic [CMP_W-1:0] cap_raw, cap, cnt, cnt_inc, cnt_dec, high, low;
    logic             is_full, is_empty;

    // capacity clamped to the ring depth
    assign cap_raw  = CMP_W'(i_cfg.capacity);
    assign cap      = (cap_raw > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_raw;
    assign cnt      = CMP_W'(r_count);
    assign cnt_inc  = cnt + 1'b1;
    assign cnt_dec  = cnt - 1'b1;
    assign high     = CMP_W'(i_cfg.high_thr);
    assign low      = CMP_W'(i_cfg.low_thr);
    assign is_full  = (cnt >= cap);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_count  = r_count;

        o_ring.wr_en   = 1'b0;
        o_ring.wr_idx  = r_wr_idx;
        o_ring.wr_data = i_buf_handle[STORE_W-1:0];
        o_ring.rd_en   = 1'b0;
        o_ring.rd_idx  = r_rd_idx;

        o_result.status       = ST_OK;
        o_result.handle_valid = 1'b0;
        o_result.event_res    = EV_NONE;

        if (i_cmd == CMD_ENQ) begin
            if (is_full) begin
                o_result.status = ST_FULL;
            end else begin
                o_ring.wr_en = i_accept;
                n_wr_idx     = next_idx(r_wr_idx);
                n_count      = r_count + 1'b1;
                // high watermark only fires below capacity; a push that reaches capacity raises full instead
                if (high < cap && cnt_inc == high) begin
                    if (i_cfg.ev_mask[MASK_HIGH]) o_result.event_res = EV_HIGH;
                    else                          o_result.status    = ST_HIGH;
                end else if (cnt_inc == cap) begin
                    if (i_cfg.ev_mask[MASK_FULL]) o_result.event_res = EV_FULL;
                end
            end
        end else begin
            if (is_empty) begin
                o_result.status = ST_EMPTY;
            end else begin
                o_ring.rd_en          = i_accept;
                o_result.handle_valid = 1'b1;
                n_rd_idx              = next_idx(r_rd_idx);
                n_count               = r_count - 1'b1;
                // emptying pop skips the low check
                if (cnt_dec == '0) begin
                    if (i_cfg.ev_mask[MASK_EMPTY]) o_result.event_res = EV_EMPTY;
                end else if (low != '0 && cnt_dec == low) begin
                    if (i_cfg.ev_mask[MASK_LOW]) o_result.event_res = EV_LOW;
                    else                         o_result.status    = ST_LOW;
                end
            end
        end

        o_result.occupancy = REG_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above ring depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_cmd == CMD_ENQ && !is_full |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not raise the count");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_idx == r_rd_idx)
        else $error("empty ring with split pointers");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.wr_en |-> i_accept && !is_full && !o_ring.rd_en)
        else $error("ring write outside an accepted push");

endmodule

`default_nettype wire
